// File: rtl/mfe_pkg.sv
// Package for the 14-bit control change fade envelope.
// Holds field widths, register indexes, phase and sequencer codes and the shared structs.
// No dependencies; every other file of the block imports it.
package mfe_pkg;

    localparam int CH_W        = 4;
    localparam int CC_W        = 7;
    localparam int VAL_W       = 14;
    localparam int HALF_W      = 7;
    localparam int TIME_W      = 16;
    localparam int STEP_W      = 24;
    localparam int DVD_W       = 24;
    localparam int DIV_CNT_W   = $clog2(DVD_W);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int FADE_SCALE    = 1000;
    localparam int MIN_FADE      = 20;
    localparam int LSB_CC_OFFSET = 32;
    localparam int TICK_RATE_DEF = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL  = 3'd0,
        REG_CC       = 3'd1,
        REG_START    = 3'd2,
        REG_HOLD     = 3'd3,
        REG_END      = 3'd4,
        REG_FADE_IN  = 3'd5,
        REG_FADE_OUT = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_RISE      = 2'd0,
        PH_FALL_DOWN = 2'd1,
        PH_FALL_UP   = 2'd2
    } phase_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } seq_state_t;

    typedef struct packed {
        logic             busy;
        logic             done;
    } div_status_t;

    typedef struct packed {
        logic [VAL_W-1:0]  level;
        logic [STEP_W-1:0] step;
        logic [VAL_W-1:0]  target;
        logic              up;
        logic              jump;
    } ramp_req_t;

    typedef struct packed {
        logic [VAL_W-1:0]  level;
        logic              finished;
    } ramp_res_t;

endpackage

// File: rtl/mfe_ifs.sv
// Channel interfaces of the fade envelope: command requests in, control change requests out.
// Depends on mfe_pkg for the field widths.
interface mfe_cmd_if;
    import mfe_pkg::*;

    logic valid;
    logic ready;
    logic operation;
    logic gate_level;

    modport source (output valid, output operation, output gate_level, input ready);
    modport sink (input valid, input operation, input gate_level, output ready);
endinterface

interface mfe_msg_if;
    import mfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel_out;
    logic [CC_W-1:0]   cc_msb_number;
    logic [CC_W-1:0]   cc_lsb_number;
    logic [HALF_W-1:0] value_msb;
    logic [HALF_W-1:0] value_lsb;

    modport source (output valid, output channel_out, output cc_msb_number,
                    output cc_lsb_number, output value_msb, output value_lsb,
                    input ready);
    modport sink (input valid, input channel_out, input cc_msb_number,
                  input cc_lsb_number, input value_msb, input value_lsb,
                  output ready);
endinterface

// File: rtl/midi_cc14_fade_envelope.sv
// Top level of the gated linear fade for a 14-bit MIDI control change.
// Depends on mfe_pkg, mfe_ifs (channel interfaces), mfe_divider and mfe_ramp.
//
// Usage: seven configuration registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle; an index above six is ignored. Requests on
// the cmd channel are either an update tick (operation 0) or a new gate level
// (operation 1). A tick with an active fade produces one control change request
// on the msg channel carrying the channel, the MSB and LSB controller numbers and
// the 14-bit level split into two 7-bit halves. Gate requests never produce output.
//
// Timing: an accepted tick has its result in the output register on the next
// cycle. A gate change with a fade time of 20 or more starts the shared serial
// divider, which produces one quotient bit per cycle; cmd.ready stays low while
// it divides and until the step is written back. Other gate requests are taken
// without a division.
//
// Reset clears the configuration registers and the fade state to zero, with the
// fade-in phase selected and both fades inactive; the payload is not reset.
// When the receiver stalls, the result waits in the output register and
// cmd.ready stays low until it is taken, so no result is lost or overwritten.
module midi_cc14_fade_envelope #(
    parameter int TICK_RATE = mfe_pkg::TICK_RATE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfe_pkg::CFG_DATA_W-1:0] cfg_data,
    mfe_cmd_if.sink                       cmd,
    mfe_msg_if.source                     msg
);
    import mfe_pkg::*;

    // The divisor holds TICK_RATE times the largest fade time.
    localparam int DIVISOR_W = $clog2(TICK_RATE * ((1 << TIME_W) - 1) + 1);

    // Configuration registers.
    logic [CH_W-1:0]   midi_channel_reg;
    logic [CC_W-1:0]   cc_number_reg;
    logic [VAL_W-1:0]  start_value_reg;
    logic [VAL_W-1:0]  hold_value_reg;
    logic [VAL_W-1:0]  end_value_reg;
    logic [TIME_W-1:0] fade_in_time_reg;
    logic [TIME_W-1:0] fade_out_time_reg;

    // Fade state and sequencer.
    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [VAL_W-1:0]  level_reg, level_next;
    logic [STEP_W-1:0] rise_step_reg, rise_step_next;
    logic [STEP_W-1:0] fall_step_reg, fall_step_next;
    logic              rise_active_reg, rise_active_next;
    logic              fall_active_reg, fall_active_next;
    logic              last_gate_reg, last_gate_next;
    logic              div_rise_reg, div_rise_next;
    logic              out_valid_reg, out_valid_next;

    // Output payload registers.
    logic [CH_W-1:0]   chan_out_reg;
    logic [CC_W-1:0]   msb_num_reg;
    logic [CC_W-1:0]   lsb_num_reg;
    logic [HALF_W-1:0] val_msb_reg;
    logic [HALF_W-1:0] val_lsb_reg;

    logic              accept;
    logic              emit;
    logic              rise_jump;
    logic              fall_jump;
    logic              div_start;
    logic [VAL_W-1:0]  op_a;
    logic [VAL_W-1:0]  op_b;
    logic [VAL_W-1:0]  op_diff;
    logic [DVD_W-1:0]  dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [DVD_W-1:0]  quotient;
    div_status_t       div_stat;
    ramp_req_t         ramp_req;
    ramp_res_t         ramp_res;

    // A new request is taken only while the divider is quiet and the output
    // register is free or being emptied in this cycle.
    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || msg.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign rise_jump = (fade_in_time_reg < TIME_W'(MIN_FADE));
    assign fall_jump = (fade_out_time_reg < TIME_W'(MIN_FADE));

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_channel_reg  <= '0;
            cc_number_reg     <= '0;
            start_value_reg   <= '0;
            hold_value_reg    <= '0;
            end_value_reg     <= '0;
            fade_in_time_reg  <= '0;
            fade_out_time_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL:  midi_channel_reg  <= cfg_data[CH_W-1:0];
                REG_CC:       cc_number_reg     <= cfg_data[CC_W-1:0];
                REG_START:    start_value_reg   <= cfg_data[VAL_W-1:0];
                REG_HOLD:     hold_value_reg    <= cfg_data[VAL_W-1:0];
                REG_END:      end_value_reg     <= cfg_data[VAL_W-1:0];
                REG_FADE_IN:  fade_in_time_reg  <= cfg_data[TIME_W-1:0];
                REG_FADE_OUT: fade_out_time_reg <= cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Step operands. A rising gate measures from start to hold over the fade-in
    // time; a falling gate measures from the present level to end over the
    // fade-out time. The scale by 1000 and by TICK_RATE are constant products.
    always_comb
    begin
        if (cmd.gate_level)
        begin
            op_a    = hold_value_reg;
            op_b    = start_value_reg;
            divisor = DIVISOR_W'(fade_in_time_reg) * DIVISOR_W'(TICK_RATE);
        end
        else
        begin
            op_a    = end_value_reg;
            op_b    = level_reg;
            divisor = DIVISOR_W'(fade_out_time_reg) * DIVISOR_W'(TICK_RATE);
        end
        op_diff  = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
        dividend = DVD_W'(op_diff) * DVD_W'(FADE_SCALE);
    end

    // The ramp unit serves whichever fade the phase selects.
    always_comb
    begin
        ramp_req.level = level_reg;
        if (phase_reg == PH_RISE)
        begin
            ramp_req.step   = rise_step_reg;
            ramp_req.target = hold_value_reg;
            ramp_req.up     = !(level_reg > hold_value_reg);
            ramp_req.jump   = rise_jump;
        end
        else
        begin
            ramp_req.step   = fall_step_reg;
            ramp_req.target = end_value_reg;
            ramp_req.up     = (phase_reg == PH_FALL_UP);
            ramp_req.jump   = fall_jump;
        end
    end

    mfe_ramp u_ramp (
        .req (ramp_req),
        .res (ramp_res)
    );

    mfe_divider #(
        .DIVISOR_W (DIVISOR_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_stat)
    );

    // Sequencer and fade state update.
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        level_next       = level_reg;
        rise_step_next   = rise_step_reg;
        fall_step_next   = fall_step_reg;
        rise_active_next = rise_active_reg;
        fall_active_next = fall_active_reg;
        last_gate_next   = last_gate_reg;
        div_rise_next    = div_rise_reg;
        div_start        = 1'b0;
        emit             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation)
                    begin
                        // A repeated gate level changes nothing.
                        if (cmd.gate_level != last_gate_reg)
                        begin
                            last_gate_next = cmd.gate_level;
                            if (cmd.gate_level)
                            begin
                                phase_next       = PH_RISE;
                                rise_active_next = 1'b1;
                                fall_active_next = 1'b0;
                                level_next       = start_value_reg;
                                if (rise_jump)
                                begin
                                    rise_step_next = '0;
                                end
                                else
                                begin
                                    div_start     = 1'b1;
                                    div_rise_next = 1'b1;
                                    state_next    = ST_DIV;
                                end
                            end
                            else
                            begin
                                rise_active_next = 1'b0;
                                fall_active_next = 1'b1;
                                if (fall_jump)
                                begin
                                    fall_step_next = '0;
                                    phase_next     = PH_FALL_DOWN;
                                end
                                else
                                begin
                                    phase_next    = (end_value_reg > level_reg) ?
                                                    PH_FALL_UP : PH_FALL_DOWN;
                                    div_start     = 1'b1;
                                    div_rise_next = 1'b0;
                                    state_next    = ST_DIV;
                                end
                            end
                        end
                    end
                    else
                    begin
                        // An update tick moves the active fade one step.
                        if (phase_reg == PH_RISE)
                        begin
                            if (rise_active_reg)
                            begin
                                emit             = 1'b1;
                                level_next       = ramp_res.level;
                                rise_active_next = !ramp_res.finished;
                            end
                        end
                        else
                        begin
                            if (fall_active_reg)
                            begin
                                emit             = 1'b1;
                                level_next       = ramp_res.level;
                                fall_active_next = !ramp_res.finished;
                            end
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_rise_reg)
                    begin
                        rise_step_next = quotient;
                    end
                    else
                    begin
                        fall_step_next = quotient;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !msg.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_RISE;
            level_reg       <= '0;
            rise_step_reg   <= '0;
            fall_step_reg   <= '0;
            rise_active_reg <= 1'b0;
            fall_active_reg <= 1'b0;
            last_gate_reg   <= 1'b0;
            div_rise_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            level_reg       <= level_next;
            rise_step_reg   <= rise_step_next;
            fall_step_reg   <= fall_step_next;
            rise_active_reg <= rise_active_next;
            fall_active_reg <= fall_active_next;
            last_gate_reg   <= last_gate_next;
            div_rise_reg    <= div_rise_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // The result carries the registers as they stand at the tick. The LSB
    // controller number wraps within seven bits.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            chan_out_reg <= midi_channel_reg;
            msb_num_reg  <= cc_number_reg;
            lsb_num_reg  <= cc_number_reg + CC_W'(LSB_CC_OFFSET);
            val_msb_reg  <= ramp_res.level[VAL_W-1:HALF_W];
            val_lsb_reg  <= ramp_res.level[HALF_W-1:0];
        end
    end

    assign msg.valid         = out_valid_reg;
    assign msg.channel_out   = chan_out_reg;
    assign msg.cc_msb_number = msb_num_reg;
    assign msg.cc_lsb_number = lsb_num_reg;
    assign msg.value_msb     = val_msb_reg;
    assign msg.value_lsb     = val_lsb_reg;

endmodule

// File: rtl/mfe_divider.sv
// Restoring serial divider that produces one quotient bit per cycle.
// Depends on mfe_pkg for the dividend width and the status struct.
module mfe_divider #(
    parameter int DIVISOR_W = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mfe_pkg::DVD_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output logic [mfe_pkg::DVD_W-1:0] quotient,
    output mfe_pkg::div_status_t     status
);
    import mfe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;

    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic [DIVISOR_W-1:0] rem_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        if (fits)
        begin
            rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/mfe_ramp.sv
// One ramp tick: the shared add, subtract and compare unit of the fade.
// Depends on mfe_pkg for the ramp request and result structs.
module mfe_ramp (
    input  mfe_pkg::ramp_req_t req,
    output mfe_pkg::ramp_res_t res
);
    import mfe_pkg::*;

    logic [STEP_W-1:0] step_eff;
    logic [STEP_W:0]   sum;
    logic [STEP_W-1:0] level_ext;
    logic [STEP_W-1:0] diff;

    always_comb
    begin
        // A zero step still moves by one so that every ramp ends.
        step_eff  = (req.step == '0) ? STEP_W'(1) : req.step;
        level_ext = STEP_W'(req.level);
        sum       = {1'b0, level_ext} + {1'b0, step_eff};
        diff      = level_ext - step_eff;

        res.level    = req.target;
        res.finished = 1'b1;
        if (!req.jump)
        begin
            if (req.up)
            begin
                if (sum < (STEP_W + 1)'(req.target))
                begin
                    res.level    = sum[VAL_W-1:0];
                    res.finished = 1'b0;
                end
            end
            else
            begin
                if ((level_ext > step_eff) && (diff > STEP_W'(req.target)))
                begin
                    res.level    = diff[VAL_W-1:0];
                    res.finished = 1'b0;
                end
            end
        end
    end

endmodule
